// File: design/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants of the LED segment pattern engine
// Holds the payload structs, the controller command and status structs,
// the mode and register codes and the LED index clamp.
// ----------------------------------------------------------------------------
package lsp_pkg;

  // Default segment count and strip length.
  localparam int SEGMENTS_DEF = 16;
  localparam int STRIP_LEDS   = 128;

  // Counter limits and register reset values.
  localparam logic [15:0] CNT_MAX         = 16'hFFFF;
  localparam logic [15:0] BLINK_HALF_RST  = 16'd250;
  localparam logic [15:0] REFRESH_PER_RST = 16'd100;
  localparam logic [7:0]  LIGHTNESS_RST   = 8'd10;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLINK_HALF  = 2'd0;
  localparam logic [1:0] CFG_REFRESH_PER = 2'd1;
  localparam logic [1:0] CFG_LIGHTNESS   = 2'd2;

  // Input operation codes.
  localparam logic OP_CONFIG = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Segment modes.
  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_ON     = 3'd1;
  localparam logic [2:0] MODE_FLOW   = 3'd2;
  localparam logic [2:0] MODE_BLINK  = 3'd3;
  localparam logic [2:0] MODE_ROTATE = 3'd4;

  // Write slots of a rotate segment.
  localparam logic [1:0] SUB_CLEAR = 2'd0;
  localparam logic [1:0] SUB_POS   = 2'd1;
  localparam logic [1:0] SUB_NEXT  = 2'd2;

  typedef struct packed {
    logic       op;
    logic [3:0] segment;
    logic [6:0] range_start;
    logic [6:0] range_end;
    logic [2:0] mode;
  } in_item_t;

  typedef struct packed {
    logic [3:0] seg_id;
    logic       strip;
    logic [6:0] first_led;
    logic [6:0] last_led;
    logic       color_on;
    logic       full_bright;
    logic [7:0] level;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLINK,
    ST_REFRESH,
    ST_FLUSH
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cfg_item;
    logic       tick;
    logic       emit;
    logic       scan_refresh;
    logic       flush;
    logic [1:0] sub;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick_blink;
    logic tick_refresh;
    logic refresh_due;
    logic needs_write;
    logic final_sub;
    logic out_free;
    logic hold_valid;
  } dp_sts_t;

  // Saturate an LED index to the strip length.
  function automatic logic [6:0] clamp_led(logic [6:0] v);
    logic [10:0] wide;
    wide = {4'b0000, v};
    if (wide > 11'(STRIP_LEDS - 1)) begin
      return 7'(STRIP_LEDS - 1);
    end
    return v;
  endfunction

endpackage

// File: design/lsp_ctrl.sv
// ----------------------------------------------------------------------------
// lsp_ctrl: sequencer of the LED segment pattern engine
// Walks the blink scan and the refresh scan over all segments, steps the
// rotate write slots and flushes the final write of each tick.
// ----------------------------------------------------------------------------
module lsp_ctrl #(
  parameter int SEGMENTS = lsp_pkg::SEGMENTS_DEF,
  localparam int SegW = $clog2(SEGMENTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_stall,
  input  lsp_pkg::dp_sts_t  sts,
  output lsp_pkg::ctl_cmd_t cmd,
  output logic [SegW-1:0]   idx
);

  lsp_pkg::ctl_state_t state_r, state_nxt;
  logic [SegW-1:0] idx_r, idx_nxt;
  logic [1:0]      sub_r, sub_nxt;
  logic            in_acc;
  logic            step_go;
  logic            idx_last;

  assign in_acc   = in_valid && (state_r == lsp_pkg::ST_IDLE);
  assign step_go  = !sts.needs_write || sts.out_free;
  assign idx_last = (idx_r == SegW'(SEGMENTS - 1));

  // Next state and scan counters.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sub_nxt   = sub_r;
    unique case (state_r)
      lsp_pkg::ST_IDLE: begin
        idx_nxt = '0;
        sub_nxt = lsp_pkg::SUB_CLEAR;
        if (in_acc && in_op == lsp_pkg::OP_TICK) begin
          if (sts.tick_blink) begin
            state_nxt = lsp_pkg::ST_BLINK;
          end else if (sts.tick_refresh) begin
            state_nxt = lsp_pkg::ST_REFRESH;
          end
        end
      end
      lsp_pkg::ST_BLINK, lsp_pkg::ST_REFRESH: begin
        if (step_go) begin
          if (sts.needs_write && !sts.final_sub) begin
            sub_nxt = sub_r + 2'd1;
          end else begin
            sub_nxt = lsp_pkg::SUB_CLEAR;
            if (idx_last) begin
              idx_nxt = '0;
              if (state_r == lsp_pkg::ST_BLINK && sts.refresh_due) begin
                state_nxt = lsp_pkg::ST_REFRESH;
              end else begin
                state_nxt = lsp_pkg::ST_FLUSH;
              end
            end else begin
              idx_nxt = idx_r + SegW'(1);
            end
          end
        end
      end
      lsp_pkg::ST_FLUSH: begin
        if (!sts.hold_valid || sts.out_free) begin
          state_nxt = lsp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lsp_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_stall         = (state_r != lsp_pkg::ST_IDLE);
    cmd              = '0;
    cmd.sub          = sub_r;
    cmd.cfg_item     = in_acc && (in_op == lsp_pkg::OP_CONFIG);
    cmd.tick         = in_acc && (in_op == lsp_pkg::OP_TICK);
    cmd.scan_refresh = (state_r == lsp_pkg::ST_REFRESH);
    cmd.emit         = (state_r == lsp_pkg::ST_BLINK || state_r == lsp_pkg::ST_REFRESH)
                       && sts.needs_write && sts.out_free;
    cmd.flush        = (state_r == lsp_pkg::ST_FLUSH) && sts.hold_valid && sts.out_free;
  end

  assign idx = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsp_pkg::ST_IDLE;
      idx_r   <= '0;
      sub_r   <= lsp_pkg::SUB_CLEAR;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      sub_r   <= sub_nxt;
    end
  end

endmodule

// File: design/lsp_datapath.sv
// ----------------------------------------------------------------------------
// lsp_datapath: segment store, timers and write builder
// Keeps the segment table and the configuration registers, runs the blink
// and refresh counters on a tick and builds one range write per command,
// holding it in a hold stage until the next one arrives, so that the final write of a tick can be marked.
// ----------------------------------------------------------------------------
module lsp_datapath #(
  parameter int SEGMENTS = lsp_pkg::SEGMENTS_DEF,
  localparam int SegW = $clog2(SEGMENTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  lsp_pkg::in_item_t  in_item,
  input  lsp_pkg::ctl_cmd_t  cmd,
  input  logic [SegW-1:0]    idx,
  output lsp_pkg::dp_sts_t   sts,
  output logic               out_valid,
  input  logic               out_stall,
  output lsp_pkg::out_item_t out_item
);

  // Configuration registers.
  logic [15:0] blink_half_r;
  logic [15:0] refresh_per_r;
  logic [7:0]  lightness_r;

  // Segment table.
  logic [6:0] seg_first_r [SEGMENTS];
  logic [6:0] seg_last_r  [SEGMENTS];
  logic [2:0] seg_mode_r  [SEGMENTS];
  logic [6:0] seg_pos_r   [SEGMENTS];

  // Timers.
  logic        phase_r, phase_nxt;
  logic [15:0] blink_cnt_r, blink_cnt_nxt;
  logic [15:0] refresh_cnt_r, refresh_cnt_nxt;
  logic        refresh_due_r, refresh_due_nxt;

  // Hold stage and output register.
  lsp_pkg::out_item_t hold_r, hold_nxt;
  logic               hold_valid_r, hold_valid_nxt;
  lsp_pkg::out_item_t out_item_r, out_item_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic        any_blink;
  logic [15:0] blink_inc;
  logic [15:0] refresh_inc;
  logic        blink_toggle;
  logic        refresh_hit;

  logic [6:0] cur_a, cur_b, cur_p, rot_p;
  logic [2:0] cur_mode;
  logic [7:0] p_inc, rot_inc;
  logic [6:0] rot_nx, pos_new;
  logic       out_free;
  logic       pos_we;
  logic [SegW-1:0] cfg_seg;
  logic       cfg_seg_ok;
  lsp_pkg::out_item_t wr;

  // Blink activity across all segments.
  always_comb begin
    any_blink = 1'b0;
    for (int i = 0; i < SEGMENTS; i++) begin
      if (seg_mode_r[i] == lsp_pkg::MODE_BLINK) begin
        any_blink = 1'b1;
      end
    end
  end

  // Saturating timer steps for a tick.
  assign blink_inc    = (blink_cnt_r == lsp_pkg::CNT_MAX) ? blink_cnt_r : blink_cnt_r + 16'd1;
  assign refresh_inc  = (refresh_cnt_r == lsp_pkg::CNT_MAX) ? refresh_cnt_r
                                                            : refresh_cnt_r + 16'd1;
  assign blink_toggle = any_blink && (blink_inc >= blink_half_r);
  assign refresh_hit  = (refresh_inc > refresh_per_r);

  always_comb begin
    phase_nxt       = phase_r;
    blink_cnt_nxt   = blink_cnt_r;
    refresh_cnt_nxt = refresh_cnt_r;
    refresh_due_nxt = refresh_due_r;
    if (cmd.tick) begin
      if (!any_blink) begin
        phase_nxt     = 1'b1;
        blink_cnt_nxt = '0;
      end else if (blink_toggle) begin
        phase_nxt     = !phase_r;
        blink_cnt_nxt = '0;
      end else begin
        blink_cnt_nxt = blink_inc;
      end
      refresh_cnt_nxt = refresh_hit ? 16'd0 : refresh_inc;
      refresh_due_nxt = refresh_hit;
    end
  end

  // Current segment and its write for the present slot.
  assign cur_a    = seg_first_r[idx];
  assign cur_b    = seg_last_r[idx];
  assign cur_p    = seg_pos_r[idx];
  assign cur_mode = seg_mode_r[idx];

  assign p_inc   = {1'b0, cur_p} + 8'd1;
  assign rot_p   = (cur_p < cur_a || cur_p > cur_b) ? cur_a : cur_p;
  assign rot_inc = {1'b0, rot_p} + 8'd1;
  assign rot_nx  = (rot_inc > {1'b0, cur_b}) ? cur_a : rot_inc[6:0];

  always_comb begin
    wr             = '0;
    wr.seg_id      = 4'(idx);
    wr.strip       = idx[0];
    wr.first_led   = cur_a;
    wr.last_led    = cur_b;
    wr.level       = lightness_r;
    wr.last        = 1'b0;
    pos_new        = cur_p;
    pos_we         = 1'b0;
    unique case (cur_mode)
      lsp_pkg::MODE_ON: begin
        wr.color_on    = 1'b1;
        wr.full_bright = 1'b1;
      end
      lsp_pkg::MODE_BLINK: begin
        wr.color_on    = phase_r;
        wr.full_bright = phase_r;
      end
      lsp_pkg::MODE_FLOW: begin
        pos_we         = 1'b1;
        wr.full_bright = 1'b1;
        if (p_inc > {1'b0, cur_b}) begin
          pos_new     = cur_a;
          wr.color_on = 1'b0;
        end else begin
          pos_new     = p_inc[6:0];
          wr.color_on = 1'b1;
          wr.last_led = p_inc[6:0];
        end
      end
      lsp_pkg::MODE_ROTATE: begin
        pos_new = rot_nx;
        pos_we  = (cmd.sub == lsp_pkg::SUB_NEXT);
        case (cmd.sub)
          lsp_pkg::SUB_POS: begin
            wr.first_led   = rot_p;
            wr.last_led    = rot_p;
            wr.color_on    = 1'b1;
            wr.full_bright = 1'b1;
          end
          lsp_pkg::SUB_NEXT: begin
            wr.first_led   = rot_nx;
            wr.last_led    = rot_nx;
            wr.color_on    = 1'b1;
            wr.full_bright = 1'b1;
          end
          default: begin
            wr.color_on    = 1'b0;
            wr.full_bright = 1'b0;
          end
        endcase
      end
      default: begin
        wr.color_on    = 1'b0;
        wr.full_bright = 1'b0;
      end
    endcase
  end

  // Status back to the controller.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    sts              = '0;
    sts.tick_blink   = blink_toggle;
    sts.tick_refresh = refresh_hit;
    sts.refresh_due  = refresh_due_r;
    sts.out_free     = out_free;
    sts.hold_valid   = hold_valid_r;
    if (cmd.scan_refresh) begin
      sts.needs_write = (cur_mode <= lsp_pkg::MODE_ROTATE);
      sts.final_sub   = (cur_mode != lsp_pkg::MODE_ROTATE) || (cmd.sub == lsp_pkg::SUB_NEXT);
    end else begin
      sts.needs_write = (cur_mode == lsp_pkg::MODE_BLINK);
      sts.final_sub   = 1'b1;
    end
  end

  // Hold stage and output register: a write moves out once the next one arrives
  // or the tick ends, which marks it as the final write.
  always_comb begin
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    out_item_nxt   = out_item_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (cmd.emit) begin
      hold_nxt       = wr;
      hold_valid_nxt = 1'b1;
      if (hold_valid_r) begin
        out_item_nxt  = hold_r;
        out_valid_nxt = 1'b1;
      end
    end else if (cmd.flush) begin
      out_item_nxt      = hold_r;
      out_item_nxt.last = 1'b1;
      out_valid_nxt     = 1'b1;
      hold_valid_nxt    = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Configure item decode.
  assign cfg_seg    = SegW'(in_item.segment);
  assign cfg_seg_ok = (int'(in_item.segment) < SEGMENTS);

  // Segment table updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEGMENTS; i++) begin
        seg_first_r[i] <= '0;
        seg_last_r[i]  <= '0;
        seg_mode_r[i]  <= lsp_pkg::MODE_OFF;
        seg_pos_r[i]   <= '0;
      end
    end else if (cmd.cfg_item && cfg_seg_ok) begin
      seg_first_r[cfg_seg] <= lsp_pkg::clamp_led(in_item.range_start);
      seg_last_r[cfg_seg]  <= lsp_pkg::clamp_led(in_item.range_end);
      seg_mode_r[cfg_seg]  <= in_item.mode;
      seg_pos_r[cfg_seg]   <= lsp_pkg::clamp_led(in_item.range_start);
    end else if (cmd.emit && cmd.scan_refresh && pos_we) begin
      seg_pos_r[idx] <= pos_new;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_half_r  <= lsp_pkg::BLINK_HALF_RST;
      refresh_per_r <= lsp_pkg::REFRESH_PER_RST;
      lightness_r   <= lsp_pkg::LIGHTNESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsp_pkg::CFG_BLINK_HALF:  blink_half_r  <= cfg_wdata;
        lsp_pkg::CFG_REFRESH_PER: refresh_per_r <= cfg_wdata;
        lsp_pkg::CFG_LIGHTNESS:   lightness_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Timers and handshake control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= 1'b1;
      blink_cnt_r   <= '0;
      refresh_cnt_r <= '0;
      refresh_due_r <= 1'b0;
      hold_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      blink_cnt_r   <= blink_cnt_nxt;
      refresh_cnt_r <= refresh_cnt_nxt;
      refresh_due_r <= refresh_due_nxt;
      hold_valid_r  <= hold_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// File: design/led_segment_pattern_engine_core.sv
// ----------------------------------------------------------------------------
// A configure beat is taken while the controller is idle; a tick runs the blink
// scan and then the refresh scan over every segment, each only when due, with
// extra write slots for each rotate segment, and a flush of the final write.
// The controller walks one write slot a cycle while the output is not stalled.
// Reset (rst_n, synchronous) clears the segment table to off, the timers,
// and loads the register defaults 250, 100 and 10.
// ----------------------------------------------------------------------------
// led_segment_pattern_engine_core: LED segment pattern engine top level
// Joins the scan controller and the datapath.
// ----------------------------------------------------------------------------
module led_segment_pattern_engine_core #(
  parameter int SEGMENTS = lsp_pkg::SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  lsp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lsp_pkg::out_item_t out_item
);

  localparam int SegW = $clog2(SEGMENTS);

  lsp_pkg::ctl_cmd_t cmd;
  lsp_pkg::dp_sts_t  sts;
  logic [SegW-1:0]   idx;

  // Scan sequencer.
  lsp_ctrl #(
    .SEGMENTS(SEGMENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_item.op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  // Segment store, timers and write builder.
  lsp_datapath #(
    .SEGMENTS(SEGMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .idx       (idx),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: dv/led_segment_pattern_engine_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_segment_pattern_engine_core_test: self-checking bench for the LED engine
// Drives configure and tick beats through the valid/stall input channel, keeps
// a shadow copy of the segment table, timers and registers, and predicts every
// range write. Each write beat on the output channel is checked field by field
// against the oldest prediction. A short directed table is followed by random
// phases with fresh register settings and random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module led_segment_pattern_engine_core_test;

  localparam int NSEG        = 16;
  localparam int DRAIN_CYC   = 80;
  localparam int CYCLE_LIMIT = 2500000;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 26;
  localparam int PRINT_CAP   = 100;

  // One row of the directed table: a register write or an input beat.
  typedef struct {
    bit                 is_cfg;
    logic [1:0]         reg_idx;
    logic [15:0]        reg_val;
    lsp_pkg::in_item_t  item;
    bit                 chk;
    lsp_pkg::out_item_t first;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  lsp_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  lsp_pkg::out_item_t out_item;

  // Shadow registers.
  logic [15:0] half_period_reg;
  logic [15:0] refresh_period_reg;
  logic [7:0]  lightness_reg;

  // Shadow segment table and timers.
  logic [6:0]  seg_lo_led[NSEG];
  logic [6:0]  seg_hi_led[NSEG];
  logic [2:0]  seg_mode_tbl[NSEG];
  logic [6:0]  seg_cursor[NSEG];
  logic        phase_lit;
  logic [15:0] blink_ms;
  logic [15:0] refresh_ms;

  lsp_pkg::out_item_t expected_writes[$];
  stim_row_t          directed[$];
  int                 mismatches;
  int                 cycle_count;

  led_segment_pattern_engine_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t mk_cfg(logic [1:0] idx, logic [15:0] val);
    stim_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.item    = '0;
    r.chk     = 1'b0;
    r.first   = '0;
    return r;
  endfunction

  function automatic stim_row_t mk_item(lsp_pkg::in_item_t it, bit chk,
                                        lsp_pkg::out_item_t first);
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.item    = it;
    r.chk     = chk;
    r.first   = first;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Append one predicted range write.
  task automatic push_write(input logic [3:0] s, input logic [6:0] a, input logic [6:0] b,
                            input logic color, input logic bright);
    lsp_pkg::out_item_t w;
    w.seg_id      = s;
    w.strip       = s[0];
    w.first_led   = a;
    w.last_led    = b;
    w.color_on    = color;
    w.full_bright = bright;
    w.level       = lightness_reg;
    w.last        = 1'b0;
    expected_writes.push_back(w);
  endtask

  // Writes of one segment in its current mode; advances flow and rotate cursors.
  task automatic segment_writes(input int s);
    logic [6:0] a;
    logic [6:0] b;
    logic [6:0] p;
    logic [6:0] nx;
    logic [7:0] p1;
    a = seg_lo_led[s];
    b = seg_hi_led[s];
    p = seg_cursor[s];
    case (seg_mode_tbl[s])
      lsp_pkg::MODE_OFF: push_write(4'(s), a, b, 1'b0, 1'b0);
      lsp_pkg::MODE_ON: push_write(4'(s), a, b, 1'b1, 1'b1);
      lsp_pkg::MODE_BLINK: push_write(4'(s), a, b, phase_lit, phase_lit);
      lsp_pkg::MODE_FLOW: begin
        p1 = {1'b0, p} + 8'd1;
        if (p1 > {1'b0, b}) begin
          seg_cursor[s] = a;
          push_write(4'(s), a, b, 1'b0, 1'b1);
        end else begin
          seg_cursor[s] = p1[6:0];
          push_write(4'(s), a, p1[6:0], 1'b1, 1'b1);
        end
      end
      lsp_pkg::MODE_ROTATE: begin
        if (p < a || p > b) begin
          p = a;
        end
        p1 = {1'b0, p} + 8'd1;
        nx = (p1 > {1'b0, b}) ? a : p1[6:0];
        push_write(4'(s), a, b, 1'b0, 1'b0);
        push_write(4'(s), p, p, 1'b1, 1'b1);
        push_write(4'(s), nx, nx, 1'b1, 1'b1);
        seg_cursor[s] = nx;
      end
      default: ;
    endcase
  endtask

  // Predict the writes caused by one accepted input beat.
  task automatic predict_item(input lsp_pkg::in_item_t it);
    bit                 any_blink;
    lsp_pkg::out_item_t w;
    int                 base;
    base = expected_writes.size();
    if (it.op == lsp_pkg::OP_CONFIG) begin
      // Configure stores the segment and parks its cursor on the first LED.
      seg_lo_led[it.segment]   = it.range_start;
      seg_hi_led[it.segment]   = it.range_end;
      seg_mode_tbl[it.segment] = it.mode;
      seg_cursor[it.segment]   = it.range_start;
    end else begin
      any_blink = 1'b0;
      for (int i = 0; i < NSEG; i++) begin
        if (seg_mode_tbl[i] == lsp_pkg::MODE_BLINK) any_blink = 1'b1;
      end
      // Blink phase: forced on while nothing blinks.
      if (!any_blink) begin
        phase_lit = 1'b1;
        blink_ms  = '0;
      end else begin
        if (blink_ms != lsp_pkg::CNT_MAX) blink_ms = blink_ms + 16'd1;
        if (blink_ms >= half_period_reg) begin
          blink_ms  = '0;
          phase_lit = ~phase_lit;
          for (int i = 0; i < NSEG; i++) begin
            if (seg_mode_tbl[i] == lsp_pkg::MODE_BLINK) segment_writes(i);
          end
        end
      end
      // Full refresh once the elapsed count passes the period.
      if (refresh_ms != lsp_pkg::CNT_MAX) refresh_ms = refresh_ms + 16'd1;
      if (refresh_ms > refresh_period_reg) begin
        refresh_ms = '0;
        for (int i = 0; i < NSEG; i++) begin
          segment_writes(i);
        end
      end
      if (expected_writes.size() > base) begin
        w = expected_writes.pop_back();
        w.last = 1'b1;
        expected_writes.push_back(w);
      end
    end
  endtask

  // Register write; the block must be idle.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      lsp_pkg::CFG_BLINK_HALF:  half_period_reg    = val;
      lsp_pkg::CFG_REFRESH_PER: refresh_period_reg = val;
      lsp_pkg::CFG_LIGHTNESS:   lightness_reg      = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Present one beat and hold it until accepted; returns the first write slot.
  task automatic send_beat(input lsp_pkg::in_item_t it, output int base);
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    base = expected_writes.size();
    predict_item(it);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending, wait for every predicted write, then let the block finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Output side back-pressure: stall runs and free runs of random length.
  initial begin
    int run;
    bit lvl;
    out_stall = 1'b0;
    forever begin
      lvl = ($urandom_range(0, 2) == 0);
      if (lvl) begin
        run = gap_len() + 1;
      end else if ($urandom_range(0, 9) == 0) begin
        run = $urandom_range(60, 150);
      end else begin
        run = $urandom_range(1, 30);
      end
      out_stall <= lvl;
      repeat (run) @(posedge clk);
    end
  end

  // Check each accepted write beat against the oldest prediction.
  always @(posedge clk) begin
    lsp_pkg::out_item_t want;
    string              bad;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write beat %h", out_item));
      end else begin
        want = expected_writes.pop_front();
        bad  = "";
        if (out_item.seg_id      !== want.seg_id)      bad = {bad, " seg_id"};
        if (out_item.strip       !== want.strip)       bad = {bad, " strip"};
        if (out_item.first_led   !== want.first_led)   bad = {bad, " first_led"};
        if (out_item.last_led    !== want.last_led)    bad = {bad, " last_led"};
        if (out_item.color_on    !== want.color_on)    bad = {bad, " color_on"};
        if (out_item.full_bright !== want.full_bright) bad = {bad, " full_bright"};
        if (out_item.level       !== want.level)       bad = {bad, " level"};
        if (out_item.last        !== want.last)        bad = {bad, " last"};
        if (bad != "") begin
          report_mismatch($sformatf("fields%s: got %h want %h", bad, out_item, want));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int                base;
    int                burst;
    int                lo;
    int                hi;
    int                shape;
    lsp_pkg::in_item_t it;
    stim_row_t         row;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_item     = '0;
    burst       = 0;

    half_period_reg    = lsp_pkg::BLINK_HALF_RST;
    refresh_period_reg = lsp_pkg::REFRESH_PER_RST;
    lightness_reg      = lsp_pkg::LIGHTNESS_RST;
    for (int i = 0; i < NSEG; i++) begin
      seg_lo_led[i]   = '0;
      seg_hi_led[i]   = '0;
      seg_mode_tbl[i] = lsp_pkg::MODE_OFF;
      seg_cursor[i]   = '0;
    end
    phase_lit  = 1'b1;
    blink_ms   = '0;
    refresh_ms = '0;

    // Directed table. After reset every segment is off, so the first refresh
    // starts with an unlit write of segment zero.
    directed.push_back(mk_cfg(lsp_pkg::CFG_LIGHTNESS, 16'd255));
    directed.push_back(mk_cfg(lsp_pkg::CFG_REFRESH_PER, 16'd0));
    directed.push_back(mk_cfg(lsp_pkg::CFG_BLINK_HALF, 16'd1));
    directed.push_back(mk_item('{lsp_pkg::OP_TICK, 4'd0, 7'd0, 7'd0, lsp_pkg::MODE_OFF},
                               1'b1,
                               '{4'd0, 1'b0, 7'd0, 7'd0, 1'b0, 1'b0, 8'd255, 1'b0}));
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd0, 7'd0, 7'd127, lsp_pkg::MODE_ON},
                               1'b0, '0));
    // Reversed range on a flow segment.
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd1, 7'd127, 7'd0, lsp_pkg::MODE_FLOW},
                               1'b0, '0));
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd2, 7'd5, 7'd9, lsp_pkg::MODE_BLINK},
                               1'b0, '0));
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd3, 7'd10, 7'd12,
                                 lsp_pkg::MODE_ROTATE}, 1'b0, '0));
    // Undefined mode emits nothing.
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd4, 7'd3, 7'd6, 3'd7}, 1'b0, '0));
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd15, 7'd127, 7'd127,
                                 lsp_pkg::MODE_ON}, 1'b0, '0));
    // Reversed range on a rotate segment.
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd5, 7'd20, 7'd18,
                                 lsp_pkg::MODE_ROTATE}, 1'b0, '0));
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd6, 7'd0, 7'd2, lsp_pkg::MODE_FLOW},
                               1'b0, '0));
    // Half period of one: the phase drops to off and the blinker writes first.
    directed.push_back(mk_item('{lsp_pkg::OP_TICK, 4'd0, 7'd0, 7'd0, lsp_pkg::MODE_OFF},
                               1'b1,
                               '{4'd2, 1'b0, 7'd5, 7'd9, 1'b0, 1'b0, 8'd255, 1'b0}));
    directed.push_back(mk_item('{lsp_pkg::OP_TICK, 4'd9, 7'd127, 7'd127, 3'd7}, 1'b0, '0));
    directed.push_back(mk_item('{lsp_pkg::OP_TICK, 4'd0, 7'd0, 7'd0, lsp_pkg::MODE_OFF},
                               1'b0, '0));
    directed.push_back(mk_item('{lsp_pkg::OP_TICK, 4'd0, 7'd0, 7'd0, lsp_pkg::MODE_OFF},
                               1'b0, '0));
    // Zero half period toggles on every tick.
    directed.push_back(mk_cfg(lsp_pkg::CFG_BLINK_HALF, 16'd0));
    directed.push_back(mk_item('{lsp_pkg::OP_TICK, 4'd0, 7'd0, 7'd0, lsp_pkg::MODE_OFF},
                               1'b0, '0));
    directed.push_back(mk_item('{lsp_pkg::OP_TICK, 4'd0, 7'd0, 7'd0, lsp_pkg::MODE_OFF},
                               1'b0, '0));
    directed.push_back(mk_cfg(lsp_pkg::CFG_LIGHTNESS, 16'd0));
    directed.push_back(mk_cfg(lsp_pkg::CFG_REFRESH_PER, 16'hFFFF));
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd2, 7'd0, 7'd0, 3'd5}, 1'b0, '0));
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd7, 7'd127, 7'd0, 3'd6}, 1'b0, '0));
    // Nothing blinks and the refresh period is at its top: no writes.
    directed.push_back(mk_item('{lsp_pkg::OP_TICK, 4'd0, 7'd0, 7'd0, lsp_pkg::MODE_OFF},
                               1'b0, '0));
    directed.push_back(mk_cfg(lsp_pkg::CFG_REFRESH_PER, 16'd0));
    directed.push_back(mk_cfg(lsp_pkg::CFG_BLINK_HALF, 16'hFFFF));
    directed.push_back(mk_item('{lsp_pkg::OP_CONFIG, 4'd8, 7'd1, 7'd1, lsp_pkg::MODE_BLINK},
                               1'b0, '0));
    // Long half period: no toggle, refresh opens with segment zero fully lit.
    directed.push_back(mk_item('{lsp_pkg::OP_TICK, 4'd0, 7'd0, 7'd0, lsp_pkg::MODE_OFF},
                               1'b1,
                               '{4'd0, 1'b0, 7'd0, 7'd127, 1'b1, 1'b1, 8'd0, 1'b0}));
    directed.push_back(mk_item('{lsp_pkg::OP_TICK, 4'd0, 7'd0, 7'd0, lsp_pkg::MODE_OFF},
                               1'b0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table.
    foreach (directed[k]) begin
      row = directed[k];
      if (row.is_cfg) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_beat(row.item, base);
        if (row.chk && expected_writes.size() > base) begin
          expected_writes[base] = row.first;
        end
        idle_gap(gap_len());
      end
    end

    // Random phases; each starts from an idle block with new register values.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 5))
        0: write_reg(lsp_pkg::CFG_BLINK_HALF, 16'd0);
        1: write_reg(lsp_pkg::CFG_BLINK_HALF, 16'd1);
        2: write_reg(lsp_pkg::CFG_BLINK_HALF, 16'd2);
        3: write_reg(lsp_pkg::CFG_BLINK_HALF, 16'd3);
        4: write_reg(lsp_pkg::CFG_BLINK_HALF, 16'($urandom_range(4, 12)));
        default: write_reg(lsp_pkg::CFG_BLINK_HALF, 16'hFFFF);
      endcase
      case ($urandom_range(0, 6))
        0, 5: write_reg(lsp_pkg::CFG_REFRESH_PER, 16'd0);
        1: write_reg(lsp_pkg::CFG_REFRESH_PER, 16'd1);
        2: write_reg(lsp_pkg::CFG_REFRESH_PER, 16'd2);
        3: write_reg(lsp_pkg::CFG_REFRESH_PER, 16'd3);
        4: write_reg(lsp_pkg::CFG_REFRESH_PER, 16'($urandom_range(4, 10)));
        default: write_reg(lsp_pkg::CFG_REFRESH_PER, 16'hFFFF);
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(lsp_pkg::CFG_LIGHTNESS, 16'd0);
        1: write_reg(lsp_pkg::CFG_LIGHTNESS, 16'd255);
        default: write_reg(lsp_pkg::CFG_LIGHTNESS, 16'($urandom_range(0, 255)));
      endcase

      for (int n = 0; n < PHASE_BEATS; n++) begin
        it.op      = ($urandom_range(0, 99) < 55) ? lsp_pkg::OP_TICK : lsp_pkg::OP_CONFIG;
        it.segment = 4'($urandom_range(0, NSEG - 1));
        lo         = $urandom_range(0, lsp_pkg::STRIP_LEDS - 1);
        shape      = $urandom_range(0, 19);
        // Mostly short ranges so flow and rotate wrap often.
        if (shape < 14) begin
          hi = lo + $urandom_range(0, 5);
          if (hi > lsp_pkg::STRIP_LEDS - 1) hi = lsp_pkg::STRIP_LEDS - 1;
        end else if (shape < 17) begin
          hi = (lo == 0) ? 0 : $urandom_range(0, lo - 1);
        end else begin
          hi = $urandom_range(0, lsp_pkg::STRIP_LEDS - 1);
        end
        it.range_start = 7'(lo);
        it.range_end   = 7'(hi);
        it.mode        = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 4))
                                                    : 3'($urandom_range(5, 7));
        send_beat(it, base);
        if (burst == 0 && $urandom_range(0, 24) == 0) begin
          burst = $urandom_range(10, 25);
        end
        if (burst > 0) begin
          burst--;
          idle_gap(0);
        end else begin
          idle_gap(gap_len());
        end
      end
    end

    // Drain and report.
    settle();
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
